// ===== hdl/cfr_pkg.sv =====
package cfr_pkg;

   // table geometry
   localparam int FRAMES    = 64;
   localparam int FRAME_W   = $clog2(FRAMES);
   localparam int COUNT_W   = 7;
   localparam int GROUP     = 8;
   localparam int GROUP_W   = $clog2(GROUP);
   localparam int GROUPS    = FRAMES / GROUP;

   // field widths
   localparam int OP_W      = 3;
   localparam int TAG_W     = 20;
   localparam int OWNER_W   = 8;
   localparam int STATUS_W  = 2;

   localparam logic [COUNT_W-1:0] FRAMES_RESET = 7'd64;

   // opcodes
   localparam logic [OP_W-1:0] OP_ALLOC  = 3'd0;
   localparam logic [OP_W-1:0] OP_FREE   = 3'd1;
   localparam logic [OP_W-1:0] OP_ACCESS = 3'd2;
   localparam logic [OP_W-1:0] OP_PIN    = 3'd3;
   localparam logic [OP_W-1:0] OP_UNPIN  = 3'd4;

   // response status codes
   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NO_VICTIM = 2'd1;
   localparam logic [STATUS_W-1:0] ST_UNTRACKED = 2'd2;

   // controller -> datapath
   typedef struct packed {
      logic load;
      logic direct;
      logic walk_start;
      logic walk_step;
      logic mem_read;
      logic evict_commit;
   } cfr_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic need_walk;
      logic victim_hit;
      logic walk_last;
   } cfr_stat_type;

endpackage

// ===== hdl/clock_frame_replacement_unit.sv =====
// Frame table with second-chance (clock) page replacement, 64 slots.
//
// Request channel: drive req_* and raise start; the transaction is taken at
// a rising edge where start is high and busy is low. busy stays high until
// the response has been produced.
// Response channel: rsp_strobe is high for exactly one cycle with rsp_*
// valid. There is no backpressure; the receiver must take it then.
// Config: csr_write_data is loaded into frames_in_use at any edge with
// csr_write_enable high. Write it only while the block is idle.
//
// Free/access/pin/unpin, unknown ops and allocates that need no eviction
// (a free slot was found, or no victim exists) go from accept through
// search settle and decide straight to the strobe. An allocate that
// must evict walks the clock hand one slot per cycle over at most as many
// slots as are in use, then reads the victim's tag/owner memory and commits.
// The next transaction can be accepted in the strobe cycle.
//
// Reset (synchronous): all slot status bits cleared, hand at 0,
// frames_in_use = 64. Tag/owner memory is not cleared; it is only read
// for valid slots.
module clock_frame_replacement_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [cfr_pkg::OP_W-1:0]       req_op,
   input  logic [cfr_pkg::FRAME_W-1:0]    req_frame_index,
   input  logic [cfr_pkg::TAG_W-1:0]      req_page_tag,
   input  logic [cfr_pkg::OWNER_W-1:0]    req_owner_id,
   input  logic                           req_is_write,
   output logic                           rsp_strobe,
   output logic [cfr_pkg::STATUS_W-1:0]   rsp_status,
   output logic [cfr_pkg::FRAME_W-1:0]    rsp_result_frame,
   output logic                           rsp_evicted,
   output logic [cfr_pkg::TAG_W-1:0]      rsp_victim_tag,
   output logic [cfr_pkg::OWNER_W-1:0]    rsp_victim_owner,
   output logic                           rsp_victim_dirty,
   input  logic                           csr_write_enable,
   input  logic [cfr_pkg::COUNT_W-1:0]    csr_write_data
);

   // command / status between sequencer and table datapath
   cfr_pkg::cfr_cmd_type  cmd;
   cfr_pkg::cfr_stat_type stat;

   // sequencer: accept, search settle, decide, hand walk, victim read, commit
   cfr_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .cmd   (cmd),
      .busy  (busy)
   );

   // slot bits, hand, search tree, tag/owner memory and response registers
   cfr_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_op           (req_op),
      .req_frame_index  (req_frame_index),
      .req_page_tag     (req_page_tag),
      .req_owner_id     (req_owner_id),
      .req_is_write     (req_is_write),
      .rsp_strobe       (rsp_strobe),
      .rsp_status       (rsp_status),
      .rsp_result_frame (rsp_result_frame),
      .rsp_evicted      (rsp_evicted),
      .rsp_victim_tag   (rsp_victim_tag),
      .rsp_victim_owner (rsp_victim_owner),
      .rsp_victim_dirty (rsp_victim_dirty)
   );

endmodule

// ===== hdl/cfr_ctrl.sv =====
module cfr_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  cfr_pkg::cfr_stat_type stat,
   output cfr_pkg::cfr_cmd_type  cmd,
   output logic                  busy
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_LOOK   = 3'd1;
   localparam logic [2:0] S_DECIDE = 3'd2;
   localparam logic [2:0] S_WALK   = 3'd3;
   localparam logic [2:0] S_READ   = 3'd4;
   localparam logic [2:0] S_COMMIT = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_LOOK;
            end
         end
         S_LOOK: begin
            // search tree stage 1 captures the slot masks
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (stat.need_walk) begin
               cmd.walk_start = 1'b1;
               state_in       = S_WALK;
            end else begin
               cmd.direct = 1'b1;
               state_in   = S_IDLE;
            end
         end
         S_WALK: begin
            cmd.walk_step = 1'b1;
            if (stat.victim_hit || stat.walk_last) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            cmd.mem_read = 1'b1;
            state_in     = S_COMMIT;
         end
         S_COMMIT: begin
            cmd.evict_commit = 1'b1;
            state_in         = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hdl/cfr_datapath.sv =====
module cfr_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  cfr_pkg::cfr_cmd_type           cmd,
   output cfr_pkg::cfr_stat_type          stat,
   input  logic                           csr_write_enable,
   input  logic [cfr_pkg::COUNT_W-1:0]    csr_write_data,
   input  logic [cfr_pkg::OP_W-1:0]       req_op,
   input  logic [cfr_pkg::FRAME_W-1:0]    req_frame_index,
   input  logic [cfr_pkg::TAG_W-1:0]      req_page_tag,
   input  logic [cfr_pkg::OWNER_W-1:0]    req_owner_id,
   input  logic                           req_is_write,
   output logic                           rsp_strobe,
   output logic [cfr_pkg::STATUS_W-1:0]   rsp_status,
   output logic [cfr_pkg::FRAME_W-1:0]    rsp_result_frame,
   output logic                           rsp_evicted,
   output logic [cfr_pkg::TAG_W-1:0]      rsp_victim_tag,
   output logic [cfr_pkg::OWNER_W-1:0]    rsp_victim_owner,
   output logic                           rsp_victim_dirty
);

   localparam int FRAMES  = cfr_pkg::FRAMES;
   localparam int FRAME_W = cfr_pkg::FRAME_W;
   localparam int COUNT_W = cfr_pkg::COUNT_W;
   localparam int GROUP   = cfr_pkg::GROUP;
   localparam int GROUP_W = cfr_pkg::GROUP_W;
   localparam int GROUPS  = cfr_pkg::GROUPS;
   localparam int GSEL_W  = FRAME_W - GROUP_W;

   // lowest set bit of one group: {found, index}
   function automatic logic [GROUP_W:0] first_set(input logic [GROUP-1:0] bits);
      logic [GROUP_W:0] r;
      r = '0;
      for (int k = GROUP - 1; k >= 0; k--) begin
         if (bits[k]) r = {1'b1, GROUP_W'(k)};
      end
      return r;
   endfunction

   // configuration
   logic [COUNT_W-1:0] frames_ff;
   logic [COUNT_W-1:0] n_eff;

   // latched request
   logic [cfr_pkg::OP_W-1:0]    op_ff;
   logic [FRAME_W-1:0]          idx_ff;
   logic [cfr_pkg::TAG_W-1:0]   tag_ff;
   logic [cfr_pkg::OWNER_W-1:0] owner_ff;
   logic                        wr_ff;

   // slot status bits
   logic [FRAMES-1:0] valid_ff, valid_in;
   logic [FRAMES-1:0] pinned_ff, pinned_in;
   logic [FRAMES-1:0] accessed_ff, accessed_in;
   logic [FRAMES-1:0] dirty_ff, dirty_in;

   // clock hand and walk state
   logic [FRAME_W-1:0] hand_ff, hand_in;
   logic [FRAME_W-1:0] ptr_ff, ptr_in;
   logic [FRAME_W-1:0] cnt_ff, cnt_in;
   logic [FRAME_W-1:0] victim_ff, victim_in;

   // search tree stage 1
   logic [FRAMES-1:0]               in_range;
   logic [FRAMES-1:0]               free_mask;
   logic [FRAMES-1:0]               unpin_mask;
   logic [GROUPS-1:0][GROUP_W:0]    free_grp_ff;
   logic [GROUPS-1:0][GROUP_W:0]    unpin_grp_ff;

   // search tree stage 2
   logic               free_found;
   logic [FRAME_W-1:0] free_slot;
   logic               unpin_found;
   logic [FRAME_W-1:0] unpin_slot;

   // tag / owner memory
   logic [cfr_pkg::TAG_W-1:0]   tag_mem [FRAMES];
   logic [cfr_pkg::OWNER_W-1:0] own_mem [FRAMES];
   logic [cfr_pkg::TAG_W-1:0]   rd_tag_ff;
   logic [cfr_pkg::OWNER_W-1:0] rd_own_ff;
   logic                        mem_we;
   logic [FRAME_W-1:0]          mem_waddr;
   logic [cfr_pkg::TAG_W-1:0]   mem_wtag;
   logic [cfr_pkg::OWNER_W-1:0] mem_wown;

   // decode
   logic               is_alloc;
   logic               is_slot_op;
   logic               n_zero;
   logic               tracked;
   logic [FRAME_W-1:0] ptr_start;
   logic [FRAME_W-1:0] ptr_next;
   logic               cur_pin;
   logic               cur_acc;

   // response registers
   logic                          strobe_ff, strobe_in;
   logic [cfr_pkg::STATUS_W-1:0]  status_ff, status_in;
   logic [FRAME_W-1:0]            rframe_ff, rframe_in;
   logic                          evicted_ff, evicted_in;
   logic [cfr_pkg::TAG_W-1:0]     vtag_ff, vtag_in;
   logic [cfr_pkg::OWNER_W-1:0]   vown_ff, vown_in;
   logic                          vdirty_ff, vdirty_in;

   assign n_eff = (frames_ff > COUNT_W'(FRAMES)) ? COUNT_W'(FRAMES) : frames_ff;

   always_comb begin
      for (int i = 0; i < FRAMES; i++) begin
         in_range[i] = (COUNT_W'(i) < n_eff);
      end
   end

   assign free_mask  = ~valid_ff & in_range;
   assign unpin_mask = ~pinned_ff & in_range;

   always_ff @(posedge clock) begin
      for (int g = 0; g < GROUPS; g++) begin
         free_grp_ff[g]  <= first_set(free_mask[g*GROUP +: GROUP]);
         unpin_grp_ff[g] <= first_set(unpin_mask[g*GROUP +: GROUP]);
      end
   end

   always_comb begin
      free_found  = 1'b0;
      free_slot   = '0;
      unpin_found = 1'b0;
      unpin_slot  = '0;
      for (int g = GROUPS - 1; g >= 0; g--) begin
         if (free_grp_ff[g][GROUP_W]) begin
            free_found = 1'b1;
            free_slot  = {GSEL_W'(g), free_grp_ff[g][GROUP_W-1:0]};
         end
         if (unpin_grp_ff[g][GROUP_W]) begin
            unpin_found = 1'b1;
            unpin_slot  = {GSEL_W'(g), unpin_grp_ff[g][GROUP_W-1:0]};
         end
      end
   end

   assign is_alloc   = (op_ff == cfr_pkg::OP_ALLOC);
   assign is_slot_op = (op_ff == cfr_pkg::OP_FREE) || (op_ff == cfr_pkg::OP_ACCESS) ||
                       (op_ff == cfr_pkg::OP_PIN) || (op_ff == cfr_pkg::OP_UNPIN);
   assign n_zero     = (n_eff == '0);
   assign tracked    = (COUNT_W'(idx_ff) < n_eff) && valid_ff[idx_ff];
   assign ptr_start  = (COUNT_W'(hand_ff) >= n_eff) ? '0 : hand_ff;
   assign ptr_next   = (COUNT_W'(ptr_ff) + COUNT_W'(1) == n_eff) ? '0 : ptr_ff + FRAME_W'(1);
   assign cur_pin    = pinned_ff[ptr_ff];
   assign cur_acc    = accessed_ff[ptr_ff];

   assign stat.need_walk  = is_alloc && !free_found && !n_zero && unpin_found;
   assign stat.victim_hit = !cur_pin && !cur_acc;
   assign stat.walk_last  = (COUNT_W'(cnt_ff) == n_eff - COUNT_W'(1));

   always_comb begin
      valid_in    = valid_ff;
      pinned_in   = pinned_ff;
      accessed_in = accessed_ff;
      dirty_in    = dirty_ff;
      hand_in     = hand_ff;
      ptr_in      = ptr_ff;
      cnt_in      = cnt_ff;
      victim_in   = victim_ff;
      mem_we      = 1'b0;
      mem_waddr   = victim_ff;
      mem_wtag    = tag_ff;
      mem_wown    = owner_ff;
      strobe_in   = 1'b0;
      status_in   = status_ff;
      rframe_in   = rframe_ff;
      evicted_in  = evicted_ff;
      vtag_in     = vtag_ff;
      vown_in     = vown_ff;
      vdirty_in   = vdirty_ff;

      if (cmd.direct) begin
         strobe_in  = 1'b1;
         status_in  = cfr_pkg::ST_OK;
         rframe_in  = '0;
         evicted_in = 1'b0;
         vtag_in    = '0;
         vown_in    = '0;
         vdirty_in  = 1'b0;
         if (is_alloc) begin
            if (free_found) begin
               valid_in[free_slot]    = 1'b1;
               pinned_in[free_slot]   = 1'b1;
               accessed_in[free_slot] = 1'b0;
               dirty_in[free_slot]    = 1'b0;
               mem_we                 = 1'b1;
               mem_waddr              = free_slot;
               rframe_in              = free_slot;
            end else begin
               // empty table leaves the hand alone; all-pinned parks it at zero
               status_in = cfr_pkg::ST_NO_VICTIM;
               if (!n_zero) hand_in = '0;
            end
         end else if (is_slot_op) begin
            if (!tracked) begin
               status_in = cfr_pkg::ST_UNTRACKED;
            end else begin
               case (op_ff)
                  cfr_pkg::OP_FREE: begin
                     valid_in[idx_ff]    = 1'b0;
                     pinned_in[idx_ff]   = 1'b0;
                     accessed_in[idx_ff] = 1'b0;
                     dirty_in[idx_ff]    = 1'b0;
                  end
                  cfr_pkg::OP_ACCESS: begin
                     accessed_in[idx_ff] = 1'b1;
                     if (wr_ff) dirty_in[idx_ff] = 1'b1;
                  end
                  cfr_pkg::OP_PIN: begin
                     pinned_in[idx_ff] = 1'b1;
                  end
                  cfr_pkg::OP_UNPIN: begin
                     pinned_in[idx_ff] = 1'b0;
                  end
                  default: begin
                  end
               endcase
            end
         end
      end

      if (cmd.walk_start) begin
         ptr_in = ptr_start;
         cnt_in = '0;
      end

      if (cmd.walk_step) begin
         if (!cur_pin && !cur_acc) begin
            victim_in = ptr_ff;
            hand_in   = ptr_next;
         end else begin
            if (!cur_pin) accessed_in[ptr_ff] = 1'b0;
            if (stat.walk_last) begin
               // full lap without a victim: lowest unpinned slot, hand parks on it
               victim_in = unpin_slot;
               hand_in   = unpin_slot;
            end else begin
               ptr_in = ptr_next;
               cnt_in = cnt_ff + FRAME_W'(1);
            end
         end
      end

      if (cmd.evict_commit) begin
         strobe_in              = 1'b1;
         status_in              = cfr_pkg::ST_OK;
         rframe_in              = victim_ff;
         evicted_in             = 1'b1;
         vtag_in                = rd_tag_ff;
         vown_in                = rd_own_ff;
         vdirty_in              = dirty_ff[victim_ff];
         valid_in[victim_ff]    = 1'b1;
         pinned_in[victim_ff]   = 1'b1;
         accessed_in[victim_ff] = 1'b0;
         dirty_in[victim_ff]    = 1'b0;
         mem_we                 = 1'b1;
         mem_waddr              = victim_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frames_ff   <= cfr_pkg::FRAMES_RESET;
         valid_ff    <= '0;
         pinned_ff   <= '0;
         accessed_ff <= '0;
         dirty_ff    <= '0;
         hand_ff     <= '0;
         strobe_ff   <= 1'b0;
      end else begin
         if (csr_write_enable) frames_ff <= csr_write_data;
         valid_ff    <= valid_in;
         pinned_ff   <= pinned_in;
         accessed_ff <= accessed_in;
         dirty_ff    <= dirty_in;
         hand_ff     <= hand_in;
         strobe_ff   <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= req_op;
         idx_ff   <= req_frame_index;
         tag_ff   <= req_page_tag;
         owner_ff <= req_owner_id;
         wr_ff    <= req_is_write;
      end
      ptr_ff     <= ptr_in;
      cnt_ff     <= cnt_in;
      victim_ff  <= victim_in;
      status_ff  <= status_in;
      rframe_ff  <= rframe_in;
      evicted_ff <= evicted_in;
      vtag_ff    <= vtag_in;
      vown_ff    <= vown_in;
      vdirty_ff  <= vdirty_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         tag_mem[mem_waddr] <= mem_wtag;
         own_mem[mem_waddr] <= mem_wown;
      end
      if (cmd.mem_read) begin
         rd_tag_ff <= tag_mem[victim_ff];
         rd_own_ff <= own_mem[victim_ff];
      end
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_status       = status_ff;
   assign rsp_result_frame = rframe_ff;
   assign rsp_evicted      = evicted_ff;
   assign rsp_victim_tag   = vtag_ff;
   assign rsp_victim_owner = vown_ff;
   assign rsp_victim_dirty = vdirty_ff;

endmodule
